FILE: hw/rtl/pdm_pkg.sv
// Shared widths, constants and types of the PWM duty meter.
`timescale 1ns / 1ps

package pdm_pkg;

   // Tick counter width and its saturation value
   localparam int COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Reported tick fields are 32 bits wide
   localparam int OUT_WIDTH = 32;

   // Prescaler
   localparam int SHIFT_WIDTH = 3;
   localparam int PRESCALE_WIDTH = 7;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = 3'd6;

   // Duty and segment fields
   localparam int DUTY_WIDTH = 7;
   localparam int SEG_WIDTH = 8;

   // Stream payload widths
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 88;

   // One captured measurement handed from the front end to the divider
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] low_width;
      logic [COUNT_WIDTH-1:0] period;
      logic                   saturated;
   } pdm_meas_type;

   // One finished result
   typedef struct packed {
      logic                  overrange;
      logic [OUT_WIDTH-1:0]  period_ticks;
      logic [OUT_WIDTH-1:0]  low_ticks;
      logic [SEG_WIDTH-1:0]  ones_segments;
      logic [SEG_WIDTH-1:0]  tens_segments;
      logic [DUTY_WIDTH-1:0] duty_percent;
   } pdm_result_type;

endpackage

FILE: hw/rtl/pdm_capture.sv
// Capture front end: prescaler, saturating tick counter and edge capture.
`timescale 1ns / 1ps

module pdm_capture (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [pdm_pkg::SHIFT_WIDTH-1:0] csr_wr_data,
   input  logic                         sample_valid,
   input  logic                         sample_level,
   output logic                         meas_valid,
   output pdm_pkg::pdm_meas_type        meas
);
   import pdm_pkg::*;

   typedef enum logic [1:0] {
      PH_WAIT_FALL,
      PH_LOW,
      PH_HIGH
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [SHIFT_WIDTH-1:0]    shift_ff;
   logic [PRESCALE_WIDTH-1:0] presc_ff, presc_in;
   logic [COUNT_WIDTH-1:0]    tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0]    first_ff, first_in;
   logic [COUNT_WIDTH-1:0]    low_ff, low_in;
   logic                      prev_ff, prev_in;
   logic                      sat_ff, sat_in;

   logic                      falling;
   logic                      rising;
   logic                      advance;
   logic [COUNT_WIDTH-1:0]    delta;
   logic [PRESCALE_WIDTH:0]   limit_wide;
   logic [PRESCALE_WIDTH-1:0] limit;

   assign falling    = prev_ff & ~sample_level;
   assign rising     = ~prev_ff & sample_level;
   assign delta      = tick_ff - first_ff;
   assign limit_wide = ({{PRESCALE_WIDTH{1'b0}}, 1'b1} << shift_ff) - 1'b1;
   assign limit      = limit_wide[PRESCALE_WIDTH-1:0];

   // Step the phase machine and the counters once per accepted beat
   always_comb begin
      phase_in   = phase_ff;
      presc_in   = presc_ff;
      tick_in    = tick_ff;
      first_in   = first_ff;
      low_in     = low_ff;
      prev_in    = prev_ff;
      sat_in     = sat_ff;
      meas_valid = 1'b0;
      advance    = 1'b0;
      if (sample_valid) begin
         prev_in = sample_level;
         advance = 1'b1;
         case (phase_ff)
            PH_WAIT_FALL: begin
               if (falling) begin
                  first_in = tick_ff;
                  phase_in = PH_LOW;
               end
            end
            PH_LOW: begin
               if (rising) begin
                  low_in   = delta;
                  phase_in = PH_HIGH;
               end
            end
            PH_HIGH: begin
               // Second falling edge closes the measurement and restarts counting
               if (falling) begin
                  meas_valid = 1'b1;
                  phase_in   = PH_WAIT_FALL;
                  advance    = 1'b0;
                  tick_in    = '0;
                  presc_in   = '0;
                  sat_in     = 1'b0;
               end
            end
            default: begin
               phase_in = PH_WAIT_FALL;
            end
         endcase
         // Prescaled tick: saturate at the top and flag it
         if (advance) begin
            if (presc_ff >= limit) begin
               presc_in = '0;
               if (tick_ff == COUNT_MAX) begin
                  sat_in = 1'b1;
               end else begin
                  tick_in = tick_ff + 1'b1;
               end
            end else begin
               presc_in = presc_ff + 1'b1;
            end
         end
      end
   end

   assign meas.low_width = low_ff;
   assign meas.period    = delta;
   assign meas.saturated = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_FALL;
         shift_ff <= SHIFT_RESET;
         presc_ff <= '0;
         tick_ff  <= '0;
         first_ff <= '0;
         low_ff   <= '0;
         prev_ff  <= 1'b1;
         sat_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         presc_ff <= presc_in;
         tick_ff  <= tick_in;
         first_ff <= first_in;
         low_ff   <= low_in;
         prev_ff  <= prev_in;
         sat_ff   <= sat_in;
         if (csr_wr_en) begin
            shift_ff <= csr_wr_data;
         end
      end
   end

endmodule

FILE: hw/rtl/pdm_divider.sv
// Bit-serial duty divider with digit split and seven-segment encoding.
`timescale 1ns / 1ps

module pdm_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pdm_pkg::pdm_meas_type  meas,
   input  logic                   res_take,
   output logic                   busy,
   output logic                   res_valid,
   output pdm_pkg::pdm_result_type res
);
   import pdm_pkg::*;

   localparam int QUOT_WIDTH = DUTY_WIDTH;
   localparam int NUM_WIDTH  = COUNT_WIDTH + QUOT_WIDTH;
   localparam int EXT_WIDTH  = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH + 1;
   localparam int CNT_WIDTH  = $clog2(QUOT_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_BIT = CNT_WIDTH'(QUOT_WIDTH - 1);
   localparam logic [EXT_WIDTH-1:0] OUT_LIMIT = EXT_WIDTH'({OUT_WIDTH{1'b1}});

   localparam logic [SEG_WIDTH-1:0] SEG_FIRST [10] = '{
      8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
   };
   localparam logic [SEG_WIDTH-1:0] SEG_SECOND [10] = '{
      8'hBE, 8'h30, 8'hAD, 8'hB9, 8'h33, 8'h9B, 8'h9F, 8'hB0, 8'hBF, 8'hBB
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Tens digit of a value below 100: count the decade thresholds passed
   function automatic logic [3:0] tens_of(input logic [DUTY_WIDTH-1:0] value);
      logic [3:0] digit;
      digit = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (value >= DUTY_WIDTH'(10 * k)) begin
            digit = digit + 4'd1;
         end
      end
      return digit;
   endfunction

   // Clamp a tick count to the reported field width
   function automatic logic [OUT_WIDTH:0] clamp_out(input logic [COUNT_WIDTH-1:0] value);
      logic [EXT_WIDTH-1:0] ext;
      ext = EXT_WIDTH'(value);
      if (ext > OUT_LIMIT) begin
         return {1'b1, {OUT_WIDTH{1'b1}}};
      end
      return {1'b0, ext[OUT_WIDTH-1:0]};
   endfunction

   state_type              state_ff, state_in;
   logic [NUM_WIDTH-1:0]   rem_ff, rem_in;
   logic [NUM_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [QUOT_WIDTH-1:0]  quot_ff, quot_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   zero_ff, zero_in;
   logic [DUTY_WIDTH-1:0]  duty_ff, duty_in;
   logic [OUT_WIDTH-1:0]   low_ff, low_in;
   logic [OUT_WIDTH-1:0]   per_ff, per_in;
   logic                   over_ff, over_in;

   logic [NUM_WIDTH-1:0]   low_ext;
   logic [NUM_WIDTH-1:0]   numer;
   logic [OUT_WIDTH:0]     low_clamp;
   logic [OUT_WIDTH:0]     per_clamp;
   logic                   fits;
   logic [QUOT_WIDTH-1:0]  quot_next;
   logic [3:0]             tens;
   logic [DUTY_WIDTH-1:0]  ones_wide;
   logic [3:0]             ones;

   // Numerator 100 * low as shifted adds
   assign low_ext   = NUM_WIDTH'(meas.low_width);
   assign numer     = (low_ext << 6) + (low_ext << 5) + (low_ext << 2);
   assign low_clamp = clamp_out(meas.low_width);
   assign per_clamp = clamp_out(meas.period);

   // One quotient bit per cycle
   assign fits      = rem_ff >= dvs_ff;
   assign quot_next = {quot_ff[QUOT_WIDTH-2:0], fits};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      zero_in  = zero_ff;
      duty_in  = duty_ff;
      low_in   = low_ff;
      per_in   = per_ff;
      over_in  = over_ff;
      case (state_ff)
         ST_IDLE: begin
            // Load the operands and the clamped tick fields
            if (start) begin
               state_in = ST_RUN;
               rem_in   = numer;
               dvs_in   = NUM_WIDTH'(meas.period) << (QUOT_WIDTH - 1);
               quot_in  = '0;
               cnt_in   = LAST_BIT;
               zero_in  = (meas.period == '0);
               low_in   = low_clamp[OUT_WIDTH-1:0];
               per_in   = per_clamp[OUT_WIDTH-1:0];
               over_in  = meas.saturated | low_clamp[OUT_WIDTH] | per_clamp[OUT_WIDTH];
            end
         end
         ST_RUN: begin
            if (fits) begin
               rem_in = rem_ff - dvs_ff;
            end
            dvs_in  = dvs_ff >> 1;
            quot_in = quot_next;
            cnt_in  = cnt_ff - 1'b1;
            // Last bit: turn the quotient into the clamped duty
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
               if (zero_ff || quot_next >= DUTY_WIDTH'(100)) begin
                  duty_in = '0;
               end else if (quot_next == '0) begin
                  duty_in = DUTY_WIDTH'(99);
               end else begin
                  duty_in = DUTY_WIDTH'(100) - quot_next;
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Split the duty into digits and encode them
   assign tens      = tens_of(duty_ff);
   assign ones_wide = duty_ff - DUTY_WIDTH'({tens, 3'b000} + {2'b00, tens, 1'b0});
   assign ones      = ones_wide[3:0];

   assign busy      = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   assign res.duty_percent  = duty_ff;
   assign res.tens_segments = SEG_FIRST[tens];
   assign res.ones_segments = SEG_SECOND[ones];
   assign res.low_ticks     = low_ff;
   assign res.period_ticks  = per_ff;
   assign res.overrange     = over_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      duty_ff <= duty_in;
      low_ff  <= low_in;
      per_ff  <= per_in;
      over_ff <= over_in;
   end

endmodule

FILE: hw/rtl/pwm_duty_meter_seven_segment.sv
// PWM duty meter top level: capture front end, serial divider, output register.
// A closing falling edge starts the divider; results leave via the output register.
// Throughput: one sample beat per cycle; after a closing edge req_tready stays
// low while the 7-step serial divider runs and until rsp can take its result.
// Reset: synchronous, active high; shift returns to 6, counters and phase clear.
// A result waiting on rsp does not block sampling until the next result is due.
`timescale 1ns / 1ps

module pwm_duty_meter_seven_segment (
   input  logic                                clock,
   input  logic                                reset,
   // Sample channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pdm_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // [0] signal_level
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [6:0] duty_percent, [14:7] tens_segments, [22:15] ones_segments,
   // [54:23] low_ticks, [86:55] period_ticks, [87] zero
   output logic [pdm_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                rsp_tuser,  // [0] overrange
   // Configuration
   input  logic                                csr_wr_en,
   input  logic [pdm_pkg::SHIFT_WIDTH-1:0]     csr_wr_data  // prescale_shift
);
   import pdm_pkg::*;

   localparam int PAYLOAD_WIDTH = DUTY_WIDTH + 2 * SEG_WIDTH + 2 * OUT_WIDTH;

   logic           sample_valid;
   logic           meas_valid;
   pdm_meas_type   meas;
   logic           div_busy;
   logic           res_valid;
   logic           res_take;
   pdm_result_type res;

   logic                      rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic                      rsp_user_ff;

   // Hold samples while the divider owns a measurement
   assign req_tready   = ~div_busy;
   assign sample_valid = req_tvalid & req_tready;

   pdm_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .sample_valid (sample_valid),
      .sample_level (req_tdata[0]),
      .meas_valid   (meas_valid),
      .meas         (meas)
   );

   pdm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (meas_valid),
      .meas      (meas),
      .res_take  (res_take),
      .busy      (div_busy),
      .res_valid (res_valid),
      .res       (res)
   );

   // Move a finished result into the output register when it is free
   assign res_take = res_valid & (~rsp_valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_data_ff <= RSP_DATA_WIDTH'({res.period_ticks, res.low_ticks, res.ones_segments,
                                         res.tens_segments, res.duty_percent});
         rsp_user_ff <= res.overrange;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   if (PAYLOAD_WIDTH > RSP_DATA_WIDTH) begin : g_width_check
      $error("result payload does not fit rsp_tdata");
   end

endmodule

FILE: hw/rtl/pdm_checker.sv
// Port-level checker for the PWM duty meter, bound to the top level.
`timescale 1ns / 1ps

module pdm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [pdm_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import pdm_pkg::*;

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending and the sample side open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("meter not idle after reset");

   // Duty stays in range and is zero for a zero period
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= 7'd99 &&
                     (rsp_tdata[86:55] != 32'd0 || rsp_tdata[6:0] == 7'd0))
      else $error("duty out of range");

   // Low time never exceeds the period
   a_low_le_period: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[54:23] <= rsp_tdata[86:55])
      else $error("low time exceeds period");

   // A new result only appears after the sample side was held off
   a_result_after_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without divider activity");

endmodule

bind pwm_duty_meter_seven_segment pdm_checker u_pdm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);
